// ----- sv/hrbn_pkg.sv -----
// ----------------------------------------------------------------------------
// Held random binary noise generator: shared package
// Current width, configuration register indexes, the configuration bundle and
// the xorshift32 step function.
// ----------------------------------------------------------------------------
`default_nettype none

package hrbn_pkg;

  // Width of the signed Q3.12 current words.
  localparam int CURRENT_WIDTH = 16;

  // Largest positive current, zero-extended to 32 bits for amplitude capping.
  localparam logic [31:0] CUR_MAX_U = 32'((64'd1 << (CURRENT_WIDTH - 1)) - 64'd1);

  // Unity filter coefficient in Q1.16.
  localparam logic [16:0] ALPHA_ONE = 17'h10000;

  // Register reset values.
  localparam logic [31:0] FALLBACK_SEED_RESET   = 32'd2463534242;
  localparam logic [14:0] AMPLITUDE_LIMIT_RESET = 15'd32767;

  // Generator shift distances.
  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 17;
  localparam int SHIFT_C = 5;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_NOISE_ENABLE    = 3'd0,
    REG_NOISE_AMPLITUDE = 3'd1,
    REG_AMPLITUDE_LIMIT = 3'd2,
    REG_NOISE_SEED      = 3'd3,
    REG_FALLBACK_SEED   = 3'd4,
    REG_HOLD_TICKS      = 3'd5,
    REG_FILTER_ALPHA    = 3'd6
  } cfg_reg_t;

  // Configuration register contents as seen by the datapath.
  typedef struct packed {
    logic        noise_enable;
    logic [14:0] noise_amplitude;
    logic [14:0] amplitude_limit;
    logic [31:0] noise_seed;
    logic [31:0] fallback_seed;
    logic [15:0] hold_ticks;
    logic [16:0] filter_alpha;
  } cfg_t;

  // One xorshift32 step.
  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] x1;
    logic [31:0] x2;
    x1 = s ^ (s << SHIFT_A);
    x2 = x1 ^ (x1 >> SHIFT_B);
    return x2 ^ (x2 << SHIFT_C);
  endfunction

endpackage

`default_nettype wire

// ----- sv/hrbn_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Held random binary noise generator: configuration registers
// Decodes configuration write transactions into the register bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module hrbn_cfg_regs (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_data,
  output hrbn_pkg::cfg_t        cfg
);

  // Register file; writes to unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.noise_enable    <= 1'b0;
      cfg.noise_amplitude <= '0;
      cfg.amplitude_limit <= hrbn_pkg::AMPLITUDE_LIMIT_RESET;
      cfg.noise_seed      <= '0;
      cfg.fallback_seed   <= hrbn_pkg::FALLBACK_SEED_RESET;
      cfg.hold_ticks      <= '0;
      cfg.filter_alpha    <= hrbn_pkg::ALPHA_ONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hrbn_pkg::REG_NOISE_ENABLE:    cfg.noise_enable    <= cfg_data[0];
        hrbn_pkg::REG_NOISE_AMPLITUDE: cfg.noise_amplitude <= cfg_data[14:0];
        hrbn_pkg::REG_AMPLITUDE_LIMIT: cfg.amplitude_limit <= cfg_data[14:0];
        hrbn_pkg::REG_NOISE_SEED:      cfg.noise_seed      <= cfg_data;
        hrbn_pkg::REG_FALLBACK_SEED:   cfg.fallback_seed   <= cfg_data;
        hrbn_pkg::REG_HOLD_TICKS:      cfg.hold_ticks      <= cfg_data[15:0];
        hrbn_pkg::REG_FILTER_ALPHA:    cfg.filter_alpha    <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/hrbn_core.sv -----
// ----------------------------------------------------------------------------
// Held random binary noise generator: noise core
// Holds the generator state and computes one filtered noise sample per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module hrbn_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire hrbn_pkg::cfg_t                        cfg,
  input  wire logic                                  step,
  input  wire logic                                  tick_in,
  output logic signed [hrbn_pkg::CURRENT_WIDTH-1:0]  level,
  output logic                                       running
);

  localparam int CW = hrbn_pkg::CURRENT_WIDTH;
  localparam int PW = CW + 19;
  localparam logic signed [CW-1:0] CUR_MAX_S = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CUR_MIN_S = {1'b1, {(CW-1){1'b0}}};

  // Generator state.
  logic [31:0]          generator_word;
  logic [31:0]          seed_in_use;
  logic [15:0]          hold_counter;
  logic signed [CW-1:0] target_level;
  logic signed [CW-1:0] filtered_level;
  logic                 was_running;

  logic [31:0]          eff_seed;
  logic                 active;
  logic                 reseed;
  logic [31:0]          base_word;
  logic [15:0]          base_count;
  logic signed [CW-1:0] base_target;
  logic signed [CW-1:0] base_filt;
  logic [31:0]          drawn_word;
  logic [14:0]          amp_req;
  logic [31:0]          amp_wide;
  logic signed [CW-1:0] amp_cw;
  logic                 draw;
  logic [31:0]          generator_word_next;
  logic [15:0]          hold_counter_next;
  logic signed [CW-1:0] target_level_next;
  logic [16:0]          alpha_c;
  logic signed [CW:0]   diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] sum;
  logic signed [CW-1:0] filtered_level_next;

  // Run condition and effective seed.
  assign eff_seed = (cfg.noise_seed != '0) ? cfg.noise_seed : cfg.fallback_seed;
  assign active   = tick_in && cfg.noise_enable && (cfg.noise_amplitude != '0);
  assign reseed   = !was_running || (seed_in_use != eff_seed);

  // State seen by this tick, after any reseed.
  assign base_word   = reseed ? eff_seed : generator_word;
  assign base_count  = reseed ? '0 : hold_counter;
  assign base_target = reseed ? '0 : target_level;
  assign base_filt   = reseed ? '0 : filtered_level;

  // Amplitude, clamped to the limit register and to the current range.
  assign amp_req  = (cfg.noise_amplitude > cfg.amplitude_limit) ?
                    cfg.amplitude_limit : cfg.noise_amplitude;
  assign amp_wide = (32'(amp_req) > hrbn_pkg::CUR_MAX_U) ?
                    hrbn_pkg::CUR_MAX_U : 32'(amp_req);
  assign amp_cw   = CW'(amp_wide);

  // Draw a new level when the hold counter has run out.
  assign drawn_word          = hrbn_pkg::xorshift32(base_word);
  assign draw                = (base_count == '0);
  assign generator_word_next = draw ? drawn_word : base_word;
  assign hold_counter_next   = draw ? cfg.hold_ticks : base_count - 16'd1;
  assign target_level_next   = draw ? (drawn_word[0] ? amp_cw : -amp_cw) : base_target;

  // First-order low-pass; the arithmetic shift rounds towards minus infinity.
  assign alpha_c = (cfg.filter_alpha > hrbn_pkg::ALPHA_ONE) ?
                   hrbn_pkg::ALPHA_ONE : cfg.filter_alpha;
  assign diff    = (CW+1)'(target_level_next) - (CW+1)'(base_filt);
  assign prod    = PW'(signed'({1'b0, alpha_c})) * PW'(diff);
  assign sum     = PW'(base_filt) + (prod >>> 16);

  // Saturate the filter output to the current range.
  always_comb begin
    if (sum > PW'(CUR_MAX_S)) begin
      filtered_level_next = CUR_MAX_S;
    end else if (sum < PW'(CUR_MIN_S)) begin
      filtered_level_next = CUR_MIN_S;
    end else begin
      filtered_level_next = CW'(sum);
    end
  end

  assign level   = active ? filtered_level_next : '0;
  assign running = active;

  // State update, once per tick taken from the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      generator_word <= hrbn_pkg::FALLBACK_SEED_RESET;
      seed_in_use    <= hrbn_pkg::FALLBACK_SEED_RESET;
      hold_counter   <= '0;
      target_level   <= '0;
      filtered_level <= '0;
      was_running    <= 1'b0;
    end else if (step) begin
      if (active) begin
        generator_word <= generator_word_next;
        seed_in_use    <= eff_seed;
        hold_counter   <= hold_counter_next;
        target_level   <= target_level_next;
        filtered_level <= filtered_level_next;
        was_running    <= 1'b1;
      end else begin
        generator_word <= eff_seed;
        seed_in_use    <= eff_seed;
        hold_counter   <= '0;
        target_level   <= '0;
        filtered_level <= '0;
        was_running    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/held_random_binary_noise_generator.sv -----
// Path: an accepted tick waits in the input register until the result register
// is free or drains. Throughput: one tick per cycle unless out_ready stalls; the
// generator and filter recurrence closes in the noise core between the two registers.
// Reset: clears both pipeline valid flags, the generator state and all
// configuration registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Held random binary noise generator: top level
// Input register, noise core and result register with valid/ready handshakes,
// plus the configuration write port.
// ----------------------------------------------------------------------------
`default_nettype none

module held_random_binary_noise_generator (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  tick_active,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [hrbn_pkg::CURRENT_WIDTH-1:0]  noise_current,
  output logic                                       noise_running,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [2:0]                            cfg_index,
  input  wire logic [31:0]                           cfg_data
);

  hrbn_pkg::cfg_t                            cfg;
  logic                                      in_full;
  logic                                      in_active;
  logic                                      advance;
  logic signed [hrbn_pkg::CURRENT_WIDTH-1:0] core_level;
  logic                                      core_running;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  hrbn_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // A tick moves into the result register when that register is free or drains.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_active <= tick_active;
    end
  end

  hrbn_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (advance),
    .tick_in (in_active),
    .level   (core_level),
    .running (core_running)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      noise_current <= core_level;
      noise_running <= core_running;
    end
  end

endmodule

`default_nettype wire
